// File: hdl/rts_pkg.sv
// ----------------------------------------------------------------------------
// rts_pkg: shared types and constants for the tune sequencer
// Payload structs, command codes, controller/datapath command set.
// ----------------------------------------------------------------------------
`default_nettype none
package rts_pkg;

    localparam int RomDepth     = 8192;
    localparam int RomAw        = 13;
    localparam int ChannelCount = 3;

    localparam logic [1:0] CMD_REG_WRITE = 2'd0;
    localparam logic [1:0] CMD_TICK      = 2'd1;
    localparam logic [1:0] CMD_ROM_LOAD  = 2'd2;

    localparam logic [1:0] VAR_A = 2'd0;
    localparam logic [1:0] VAR_B = 2'd1;
    localparam logic [1:0] VAR_C = 2'd2;

    localparam logic [1:0] REG_VARIANT = 2'd0;
    localparam logic [1:0] REG_SAMPLES = 2'd1;

    localparam logic [6:0]  MasterVolOn = 7'd100;
    localparam logic [18:0] FreqReset   = 19'd1000;
    localparam logic [7:0]  SilentByte  = 8'hff;
    localparam logic [14:0] FreqNumer   = 15'd32000;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  reg_offset;
        logic [7:0]  data;
        logic [12:0] rom_address;
    } t_in_item;

    typedef struct packed {
        logic [18:0] freq_ch0;
        logic [18:0] freq_ch1;
        logic [18:0] freq_ch2;
        logic [6:0]  vol_ch0;
        logic [6:0]  vol_ch1;
        logic [6:0]  vol_ch2;
        logic [2:0]  sample_start;
        logic [2:0]  sample_stop;
        logic [1:0]  noise_write;
        logic        noise_enable;
        logic        flip_write;
        logic [7:0]  flip_data;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic       load_item;   // capture item, clear events
        logic       do_write;    // apply register write
        logic       do_load;     // write tune ROM
        logic       toggle_phase;
        logic       rd_issue;    // present ROM address of sel channel
        logic       div_start;   // ROM data valid: start divide or silence
        logic       div_step;
        logic       ch_finish;   // commit freq/vol/position of sel channel
        logic       ch_skip;     // muted channel: vol 0
        logic       rollover;    // stop-on-rollover check
        logic       capture;     // load the output result register
        logic [1:0] sel;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] command;
        logic       phase;       // tick phase before toggle
        logic [2:0] muted;
        logic       div_done;
    } t_dp_status;

endpackage
`default_nettype wire

// File: hdl/rts_ram.sv
// ----------------------------------------------------------------------------
// rts_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rts_ram #(
    parameter int Width = 8,
    parameter int Depth = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: hdl/rts_datapath.sv
// ----------------------------------------------------------------------------
// rts_datapath: channel state, register decode, tune ROM and divider
// Restoring divider computes 32000/(256-byte), one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rts_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [1:0]         i_variant,
    input  wire logic               i_samples,
    input  wire rts_pkg::t_in_item  i_item,
    input  wire rts_pkg::t_dp_cmd   i_cmd,
    output rts_pkg::t_dp_status     o_status,
    output rts_pkg::t_out_item      o_result
);
    rts_pkg::t_in_item r_item;
    logic [10:0] r_pos   [3];
    logic [12:0] r_base  [3];
    logic [8:0]  r_mask  [3];
    logic [2:0]  r_muted;
    logic [18:0] r_freq  [3];
    logic [6:0]  r_vol   [3];
    logic [6:0]  r_mvol;
    logic        r_stop_roll;
    logic [7:0]  r_prev;
    logic        r_phase;
    logic [2:0]  r_ev_start, r_ev_stop;
    logic [1:0]  r_ev_noise;
    logic        r_ev_noise_en, r_ev_flip;
    logic [7:0]  r_ev_flip_data;
    // divider
    logic [14:0] r_quo;     // shifts numerator out, quotient in
    logic [8:0]  r_rem;
    logic [8:0]  r_divisor;
    logic [3:0]  r_cnt;
    logic        r_silent;
    rts_pkg::t_out_item r_result;
    rts_pkg::t_out_item cur_result;

    logic [12:0] ram_addr;
    logic [7:0]  ram_rdata;
    logic [12:0] rd_addr;
    logic [9:0]  trial;
    logic [7:0]  d;
    logic [10:0] next_pos;

    assign d = r_item.data;
    assign rd_addr = r_base[i_cmd.sel] + {2'b00, r_pos[i_cmd.sel]};
    assign ram_addr = i_cmd.do_load ? r_item.rom_address : rd_addr;
    assign trial = {r_rem, r_quo[14]} - {1'b0, r_divisor};
    assign next_pos = (r_pos[i_cmd.sel] + 11'd1) & {2'b00, r_mask[i_cmd.sel]};
    assign o_result = r_result;

    rts_ram #(.Width(8), .Depth(rts_pkg::RomDepth)) u_rom (
        .i_clk  (i_clk),
        .i_we   (i_cmd.do_load),
        .i_addr (ram_addr),
        .i_wdata(r_item.data),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i]  <= '0;
                r_mask[i] <= '0;
                r_freq[i] <= rts_pkg::FreqReset;
                r_vol[i]  <= '0;
            end
            r_base[0] <= 13'h0000;
            r_base[1] <= 13'h0800;
            r_base[2] <= 13'h1000;
            r_muted <= 3'b111;
            r_mvol <= '0;
            r_stop_roll <= 1'b0;
            r_prev <= '0;
            r_phase <= 1'b0;
            r_ev_start <= '0;
            r_ev_stop <= '0;
            r_ev_noise <= '0;
            r_ev_noise_en <= 1'b0;
            r_ev_flip <= 1'b0;
            r_ev_flip_data <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load_item) begin
                r_item <= i_item;
                r_ev_start <= '0;
                r_ev_stop <= '0;
                r_ev_noise <= '0;
                r_ev_noise_en <= 1'b0;
                r_ev_flip <= 1'b0;
                r_ev_flip_data <= '0;
            end
            if (i_cmd.toggle_phase) begin
                r_phase <= ~r_phase;
            end
            if (i_cmd.do_write) begin
                case (i_variant)
                    rts_pkg::VAR_A: begin
                        if (r_item.reg_offset == 2'd0) begin
                            if (i_samples && d[2] && !r_prev[2]) r_ev_start[0] <= 1'b1;
                            if (d[3]) begin
                                r_muted[0] <= 1'b1;
                                r_pos[0] <= '0;
                            end
                            r_mvol <= rts_pkg::MasterVolOn;
                            r_prev <= d;
                        end else if (r_item.reg_offset == 2'd1) begin
                            r_base[0] <= {5'd0, d[3:1], 5'd0} << 3;
                            r_mask[0] <= 9'h0ff;
                            r_stop_roll <= 1'b1;
                            r_base[1] <= 13'h0800 + {2'b00, d[6:5], 9'd0};
                            r_mask[1] <= 9'h1ff;
                            if (d[0]) r_muted[0] <= 1'b0;
                            if (d[4]) begin
                                r_muted[1] <= 1'b0;
                            end else begin
                                r_muted[1] <= 1'b1;
                                r_pos[1] <= '0;
                            end
                        end
                    end
                    rts_pkg::VAR_B, rts_pkg::VAR_C: begin
                        case (r_item.reg_offset)
                            2'd0: begin
                                r_base[0] <= {2'b00, d[2:0], 8'd0};
                                r_mask[0] <= 9'h0ff;
                                r_stop_roll <= 1'b0;
                                r_prev <= d;
                                if (i_variant == rts_pkg::VAR_B) begin
                                    if (i_samples) begin
                                        if (d[5] && !r_prev[5]) r_ev_start[2] <= 1'b1;
                                        else if (!d[5] && r_prev[5]) r_ev_stop[2] <= 1'b1;
                                        if (d[7] && !r_prev[7]) r_ev_start[1] <= 1'b1;
                                    end
                                    if (d[4]) begin
                                        r_muted[0] <= 1'b0;
                                    end else if (d[3]) begin
                                        r_muted[0] <= 1'b1;
                                    end
                                    if (d[3]) r_pos[0] <= '0;
                                    r_ev_noise <= 2'd2;
                                    r_ev_noise_en <= ~d[6];
                                end else begin
                                    if (d[3]) begin
                                        r_muted[0] <= 1'b0;
                                    end else begin
                                        r_muted[0] <= 1'b1;
                                        r_pos[0] <= {d[2:0], 8'd0};
                                    end
                                    if (d[4]) begin
                                        r_muted[2] <= 1'b0;
                                    end else begin
                                        r_muted[2] <= 1'b1;
                                        r_pos[2] <= '0;
                                    end
                                    r_ev_noise <= 2'd1;
                                    r_ev_noise_en <= ~d[7];
                                end
                            end
                            2'd1: begin
                                r_base[1] <= {2'b01, d[2:0], 8'd0};
                                r_mask[1] <= 9'h0ff;
                                if (d[3]) begin
                                    r_muted[1] <= 1'b0;
                                end else begin
                                    r_muted[1] <= 1'b1;
                                    r_pos[1] <= '0;
                                end
                            end
                            2'd2: r_mvol <= rts_pkg::MasterVolOn;
                            default: begin
                                if (i_variant == rts_pkg::VAR_C) begin
                                    r_base[2] <= {2'b10, d[6:4], 8'd0};
                                    r_mask[2] <= 9'h0ff;
                                    r_ev_flip <= 1'b1;
                                    r_ev_flip_data <= d;
                                end
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
            if (i_cmd.div_start) begin
                r_silent <= (ram_rdata == rts_pkg::SilentByte);
                r_divisor <= 9'd256 - {1'b0, ram_rdata};
                r_quo <= rts_pkg::FreqNumer;
                r_rem <= '0;
                r_cnt <= 4'd15;
            end else if (i_cmd.div_step && r_cnt != 4'd0) begin
                r_cnt <= r_cnt - 4'd1;
                if (!trial[9]) begin
                    r_rem <= trial[8:0];
                    r_quo <= {r_quo[13:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[7:0], r_quo[14]};
                    r_quo <= {r_quo[13:0], 1'b0};
                end
            end
            if (i_cmd.ch_finish) begin
                if (r_silent) begin
                    r_vol[i_cmd.sel] <= '0;
                end else begin
                    r_freq[i_cmd.sel] <= {r_quo, 4'd0};
                    r_vol[i_cmd.sel] <= r_mvol;
                end
                r_pos[i_cmd.sel] <= next_pos;
            end
            if (i_cmd.ch_skip) begin
                r_vol[i_cmd.sel] <= '0;
            end
            if (i_cmd.rollover && r_stop_roll && r_pos[0] == 11'd0) begin
                r_muted[0] <= 1'b1;
            end
            if (i_cmd.capture) begin
                r_result <= cur_result;
            end
        end
    end

    always_comb begin
        o_status.command  = r_item.command;
        o_status.phase    = r_phase;
        o_status.muted    = r_muted;
        o_status.div_done = (r_cnt == 4'd0);
        cur_result.freq_ch0 = r_freq[0];
        cur_result.freq_ch1 = r_freq[1];
        cur_result.freq_ch2 = r_freq[2];
        cur_result.vol_ch0  = r_vol[0];
        cur_result.vol_ch1  = r_vol[1];
        cur_result.vol_ch2  = r_vol[2];
        cur_result.sample_start = r_ev_start;
        cur_result.sample_stop  = r_ev_stop;
        cur_result.noise_write  = r_ev_noise;
        cur_result.noise_enable = r_ev_noise_en;
        cur_result.flip_write   = r_ev_flip;
        cur_result.flip_data    = r_ev_flip_data;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_load |-> !i_cmd.rd_issue)
        else $error("ROM load collides with tune read");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ch_finish |-> r_cnt == 4'd0)
        else $error("channel committed before divide finished");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_start) |-> r_cnt == 4'd15)
        else $error("divider did not start");
endmodule
`default_nettype wire

// File: hdl/rts_ctrl.sv
// ----------------------------------------------------------------------------
// rts_ctrl: sequencer for item handling and per-channel tick work
// Walks channels 0..2 on active ticks: read ROM, divide, commit; muted ones get vol 0.
// ----------------------------------------------------------------------------
`default_nettype none
module rts_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_fire,
    input  wire logic               i_out_ready,
    input  wire rts_pkg::t_dp_status i_status,
    output rts_pkg::t_dp_cmd        o_cmd,
    output logic                    o_in_ready,
    output logic                    o_out_valid
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_CH_START, S_RD_WAIT, S_DIV_GO, S_DIV,
        S_ROLL, S_DONE
    } t_state;

    t_state     r_state;
    logic [1:0] r_sel;
    logic       r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.sel = r_sel;
        o_cmd.load_item = i_in_fire;
        case (r_state)
            S_DISPATCH: begin
                o_cmd.do_write = (i_status.command == rts_pkg::CMD_REG_WRITE);
                o_cmd.do_load  = (i_status.command == rts_pkg::CMD_ROM_LOAD);
                o_cmd.toggle_phase = (i_status.command == rts_pkg::CMD_TICK);
            end
            S_CH_START: begin
                o_cmd.rd_issue = !i_status.muted[r_sel];
                o_cmd.ch_skip  = i_status.muted[r_sel];
            end
            S_DIV_GO: o_cmd.div_start = 1'b1;
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.ch_finish = i_status.div_done;
            end
            S_ROLL: o_cmd.rollover = 1'b1;
            // output register free or emptying this cycle
            S_DONE: o_cmd.capture = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.capture) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_in_fire) r_state <= S_DISPATCH;
                S_DISPATCH: begin
                    // phase before toggle is 1 -> this tick is active
                    if (i_status.command == rts_pkg::CMD_TICK && i_status.phase) begin
                        r_sel <= 2'd0;
                        r_state <= S_CH_START;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_CH_START: begin
                    if (i_status.muted[r_sel]) begin
                        if (r_sel == 2'd2) r_state <= S_ROLL;
                        else r_sel <= r_sel + 2'd1;
                    end else begin
                        r_state <= S_RD_WAIT;
                    end
                end
                S_RD_WAIT: r_state <= S_DIV_GO;
                S_DIV_GO: r_state <= S_DIV;
                S_DIV: begin
                    if (i_status.div_done) begin
                        if (r_sel == 2'd2) begin
                            r_state <= S_ROLL;
                        end else begin
                            r_sel <= r_sel + 2'd1;
                            r_state <= S_CH_START;
                        end
                    end
                end
                S_ROLL: r_state <= S_DONE;
                S_DONE: begin
                    if (o_cmd.capture) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input accepted mid-item");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_out_valid)
        else $error("finished item produced no result");
endmodule
`default_nettype wire

// File: hdl/rom_tune_sequencer_sound_board_core.sv
// ----------------------------------------------------------------------------
// rom_tune_sequencer_sound_board_core: three-channel tune player
// Register decode, tune ROM playback and sound event generation.
// ----------------------------------------------------------------------------
// One item in, one result out. Register writes, ROM loads and idle ticks go
// from dispatch straight to the done state, which loads the output register;
// an active tick walks the three channels in turn, a muted channel only
// getting volume 0 and an unmuted one a ROM read plus a 15-step bit-serial
// divide and commit, then the rollover check, before the result is loaded.
// A one-entry output register holds the result, so the next item is
// taken while it waits; that item's result then waits until it is consumed.
// Configuration: i_cfg_we, i_cfg_index (0 variant, 1 samples present).
`default_nettype none
module rom_tune_sequencer_sound_board_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [1:0]         i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rts_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rts_pkg::t_out_item      o_out_data
);
    logic [1:0] r_variant;
    logic       r_samples;
    rts_pkg::t_dp_cmd    cmd;
    rts_pkg::t_dp_status status;
    logic in_fire;

    assign in_fire = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= rts_pkg::VAR_A;
            r_samples <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == rts_pkg::REG_VARIANT) r_variant <= i_cfg_data;
            else if (i_cfg_index == rts_pkg::REG_SAMPLES) r_samples <= i_cfg_data[0];
        end
    end

    rts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_ready(i_out_ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid)
    );

    rts_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_variant(r_variant),
        .i_samples(r_samples),
        .i_item   (i_in_data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_out_data)
    );
endmodule
`default_nettype wire
